/* hdl/pcrs_pkg.sv */
// ----------------------------------------------------------------------------
// pcrs_pkg: shared types and constants of the Philox sampler
// Holds the Philox multipliers and key increments, field widths, register
// indexes, reset values and the word types used between modules.
// ----------------------------------------------------------------------------
package pcrs_pkg;

    localparam int WORD_W    = 32;
    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int UBITS_W   = 5;
    localparam int PROB_W    = 25;

    localparam logic [WORD_W-1:0] PHILOX_M0 = 32'hD251_1F53;
    localparam logic [WORD_W-1:0] PHILOX_M1 = 32'hCD9E_8D57;
    localparam logic [WORD_W-1:0] PHILOX_W0 = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] PHILOX_W1 = 32'hBB67_AE85;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED         = 3'd0,
        REG_BASE_OFFSET  = 3'd1,
        REG_MODE         = 3'd2,
        REG_UNIFORM_BITS = 3'd3,
        REG_PROBABILITY  = 3'd4
    } cfg_reg_t;

    localparam logic MODE_BERNOULLI = 1'b0;
    localparam logic MODE_UNIFORM   = 1'b1;

    localparam logic [UBITS_W-1:0] UBITS_MIN = 5'd1;
    localparam logic [UBITS_W-1:0] UBITS_MAX = 5'd24;
    localparam logic [PROB_W-1:0]  PROB_RST  = 25'h080_0000;

    // One four-word Philox block.
    typedef struct packed {
        logic [WORD_W-1:0] c0;
        logic [WORD_W-1:0] c1;
        logic [WORD_W-1:0] c2;
        logic [WORD_W-1:0] c3;
    } block_t;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        block_t              blk;
    } result_t;

endpackage

/* hdl/pcrs_channels.sv */
// ----------------------------------------------------------------------------
// pcrs_channels: valid/ready channel interfaces of the Philox sampler
// The feed channel carries element indexes in, the result channel carries
// the sample and the four Philox words out.
// ----------------------------------------------------------------------------
interface pcrs_feed_if;
    import pcrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] element_index;

    modport source (output valid, output element_index, input ready);
    modport sink (input valid, input element_index, output ready);
endinterface

interface pcrs_result_if;
    import pcrs_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [WORD_W-1:0]   word_zero;
    logic [WORD_W-1:0]   word_one;
    logic [WORD_W-1:0]   word_two;
    logic [WORD_W-1:0]   word_three;

    modport source (output valid, output sample, output word_zero, output word_one,
                    output word_two, output word_three, input ready);
    modport sink (input valid, input sample, input word_zero, input word_one,
                  input word_two, input word_three, output ready);
endinterface

/* hdl/pcrs_round.sv */
// ----------------------------------------------------------------------------
// pcrs_round: one registered Philox4x32 round
// Two 32x32 products, the key mix for this round and the output register.
// ----------------------------------------------------------------------------
module pcrs_round #(
    parameter int ROUND_IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid_in,
    input  pcrs_pkg::block_t               blk_in,
    input  logic [pcrs_pkg::CFG_W-1:0]     seed,
    output logic                           valid_out,
    output pcrs_pkg::block_t               blk_out
);
    import pcrs_pkg::*;

    // The key of round r is the seed bumped r times; the bump is a constant.
    localparam logic [WORD_W-1:0] K0_INC = WORD_W'(64'(PHILOX_W0) * 64'(ROUND_IDX));
    localparam logic [WORD_W-1:0] K1_INC = WORD_W'(64'(PHILOX_W1) * 64'(ROUND_IDX));

    logic [2*WORD_W-1:0] prod_a;
    logic [2*WORD_W-1:0] prod_b;
    logic [WORD_W-1:0]   k0;
    logic [WORD_W-1:0]   k1;
    block_t              blk_next;
    logic                valid_reg;
    block_t              blk_reg;

    assign prod_a = {{WORD_W{1'b0}}, PHILOX_M0} * {{WORD_W{1'b0}}, blk_in.c0};
    assign prod_b = {{WORD_W{1'b0}}, PHILOX_M1} * {{WORD_W{1'b0}}, blk_in.c2};
    assign k0     = seed[WORD_W-1:0] + K0_INC;
    assign k1     = seed[2*WORD_W-1:WORD_W] + K1_INC;

    always_comb
    begin
        blk_next.c0 = prod_b[2*WORD_W-1:WORD_W] ^ blk_in.c1 ^ k0;
        blk_next.c1 = prod_b[WORD_W-1:0];
        blk_next.c2 = prod_a[2*WORD_W-1:WORD_W] ^ blk_in.c3 ^ k1;
        blk_next.c3 = prod_a[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blk_reg <= blk_next;
        end
    end

    assign valid_out = valid_reg;
    assign blk_out   = blk_reg;

endmodule

/* hdl/philox_counter_rng_sampler.sv */
// ----------------------------------------------------------------------------
// philox_counter_rng_sampler: pipelined Philox4x32 sampler
// Forms a 64-bit counter from base offset and element index, runs the
// Philox rounds in a pipeline and returns the four words and one sample.
// ----------------------------------------------------------------------------
// The block takes one element index per clock cycle while the skid stage is
// empty and returns one result word per index, in order. The accepting edge
// loads the 64-bit counter add into the first register, then comes one
// pipeline stage per Philox round (each stage holds the round's two 32x32
// multipliers and the key mix), and last the output register, where the
// sample is also formed.
// The output register has a one-word skid stage behind it, so the pipeline
// keeps accepting while a finished word waits; only when the skid stage is
// also occupied does the whole pipeline hold, losing and repeating nothing.
// Configuration registers are to be written only while no word is in flight.
// ----------------------------------------------------------------------------
module philox_counter_rng_sampler #(
    parameter int ROUNDS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pcrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcrs_pkg::CFG_W-1:0]        cfg_data,
    pcrs_feed_if.sink                         feed,
    pcrs_result_if.source                     result
);
    import pcrs_pkg::*;

    // Configuration registers, held raw; saturation is applied where used.
    logic [CFG_W-1:0]   seed_reg;
    logic [CFG_W-1:0]   base_offset_reg;
    logic               mode_reg;
    logic [UBITS_W-1:0] uniform_bits_reg;
    logic [PROB_W-1:0]  probability_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg         <= '0;
            base_offset_reg  <= '0;
            mode_reg         <= MODE_UNIFORM;
            uniform_bits_reg <= UBITS_MAX;
            probability_reg  <= PROB_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SEED:         seed_reg         <= cfg_data;
                REG_BASE_OFFSET:  base_offset_reg  <= cfg_data;
                REG_MODE:         mode_reg         <= cfg_data[0];
                REG_UNIFORM_BITS: uniform_bits_reg <= cfg_data[UBITS_W-1:0];
                REG_PROBABILITY:  probability_reg  <= cfg_data[PROB_W-1:0];
                default:          ;
            endcase
        end
    end

    // The whole pipeline advances together unless the skid stage is occupied.
    // The enable therefore comes from a register and never from result.ready.
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    result_t main_reg;
    logic    en;

    assign en         = !skid_valid_reg;
    assign feed.ready = en;

    // Stage zero holds the counter block: the index added to the base offset,
    // wrapping modulo 2^64, with words c2 and c3 cleared.
    logic [ROUNDS:0]  stage_valid;
    block_t           stage_blk [ROUNDS+1];
    logic [CFG_W-1:0] ctr;
    logic             stage0_valid_reg;
    block_t           stage0_blk_reg;

    assign ctr = base_offset_reg + {{(CFG_W-WORD_W){1'b0}}, feed.element_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            stage0_valid_reg <= feed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage0_blk_reg.c0 <= ctr[WORD_W-1:0];
            stage0_blk_reg.c1 <= ctr[CFG_W-1:WORD_W];
            stage0_blk_reg.c2 <= '0;
            stage0_blk_reg.c3 <= '0;
        end
    end

    assign stage_valid[0] = stage0_valid_reg;
    assign stage_blk[0]   = stage0_blk_reg;

    // One registered stage per round, each with its own constant key bump.
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        pcrs_round #(
            .ROUND_IDX (r)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (stage_valid[r]),
            .blk_in    (stage_blk[r]),
            .seed      (seed_reg),
            .valid_out (stage_valid[r+1]),
            .blk_out   (stage_blk[r+1])
        );
    end

    // Sample selection on the last round's word 0. In uniform mode the kept
    // bit count is clamped to one through twenty-four. In Bernoulli mode the
    // 25-bit compare saturates by itself: any probability of 2^24 or more
    // exceeds every 24-bit value, so the sample is then always one.
    logic [UBITS_W-1:0]  ubits_eff;
    logic [5:0]          ushift;
    logic [SAMPLE_W-1:0] sample_next;
    result_t             last_result;
    logic                push;

    always_comb
    begin
        if (uniform_bits_reg < UBITS_MIN)
        begin
            ubits_eff = UBITS_MIN;
        end
        else if (uniform_bits_reg > UBITS_MAX)
        begin
            ubits_eff = UBITS_MAX;
        end
        else
        begin
            ubits_eff = uniform_bits_reg;
        end
    end

    assign ushift = 6'(WORD_W) - {1'b0, ubits_eff};

    always_comb
    begin
        if (mode_reg == MODE_UNIFORM)
        begin
            sample_next = SAMPLE_W'(stage_blk[ROUNDS].c0 >> ushift);
        end
        else
        begin
            sample_next = ({1'b0, stage_blk[ROUNDS].c0[WORD_W-1:8]} < probability_reg)
                          ? SAMPLE_W'(1) : '0;
        end
    end

    assign last_result.sample = sample_next;
    assign last_result.blk    = stage_blk[ROUNDS];
    assign push               = en && stage_valid[ROUNDS];

    // Output register with a skid stage. A word arriving while the output
    // is stalled parks in the skid stage, which then holds the pipeline.
    logic    main_valid_next;
    result_t main_next;
    logic    main_load;
    logic    skid_valid_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        main_load       = 1'b0;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || result.ready)
        begin
            main_load = 1'b1;
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = last_result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
        begin
            main_reg <= main_next;
        end
        if (push && main_valid_reg && !result.ready)
        begin
            skid_reg <= last_result;
        end
    end

    assign result.valid      = main_valid_reg;
    assign result.sample     = main_reg.sample;
    assign result.word_zero  = main_reg.blk.c0;
    assign result.word_one   = main_reg.blk.c1;
    assign result.word_two   = main_reg.blk.c2;
    assign result.word_three = main_reg.blk.c3;

    // The skid stage is only ever filled behind an occupied output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage occupied while output register is empty");

    // The skid stage fills only when a word met a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !result.ready))
        else $error("skid stage filled without an output stall");

    // An accepted index must occupy the counter stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (feed.valid && feed.ready) |=> stage0_valid_reg)
        else $error("accepted index lost at the counter stage");

    // While the pipeline is held, no valid bit in it may move.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(stage_valid))
        else $error("pipeline moved while held by the skid stage");

endmodule
